// File: design/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text encoder package
// Symbol codes, character classes, the Morse code table and the request
// record that travels from the decoder to the output serialiser.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Output symbol codes
  typedef enum logic [2:0] {
    SYM_DOT  = 3'd0,
    SYM_DASH = 3'd1,
    SYM_LGAP = 3'd2,
    SYM_WGAP = 3'd3,
    SYM_ERR  = 3'd4
  } sym_t;

  // Character classes; digits and symbols each have their own enable
  typedef enum logic [1:0] {
    CLS_LETTER = 2'd0,
    CLS_DIGIT  = 2'd1,
    CLS_SYMBOL = 2'd2
  } cls_t;

  // Configuration register indexes
  localparam logic REG_ENABLE_DIGITS  = 1'b0;
  localparam logic REG_ENABLE_SYMBOLS = 1'b1;

  // Most results one character can cause: a gap and six elements.
  localparam int MAX_SYMS = 7;

  // One table entry. The pattern is left aligned: bit 5 is the first
  // element, a one is a dash and a zero a dot.
  typedef struct packed {
    logic       found;
    cls_t       cls;
    logic [2:0] len;
    logic [5:0] bits;
  } code_t;

  // Decoded results of one character, first result in slot 0.
  typedef struct packed {
    logic [2:0]                count;
    sym_t [MAX_SYMS-1:0]       syms;
  } job_t;

  function automatic code_t mk(cls_t cls, logic [2:0] len, logic [5:0] bits);
    code_t c;
    c.found = 1'b1;
    c.cls   = cls;
    c.len   = len;
    c.bits  = bits;
    return c;
  endfunction

  // Morse code table, indexed by the ASCII code
  function automatic code_t morse_lookup(logic [7:0] ch);
    code_t c;
    c = '{found: 1'b0, cls: CLS_LETTER, len: 3'd0, bits: 6'd0};
    case (ch)
      "a": c = mk(CLS_LETTER, 3'd2, 6'b010000);
      "b": c = mk(CLS_LETTER, 3'd4, 6'b100000);
      "c": c = mk(CLS_LETTER, 3'd4, 6'b101000);
      "d": c = mk(CLS_LETTER, 3'd3, 6'b100000);
      "e": c = mk(CLS_LETTER, 3'd1, 6'b000000);
      "f": c = mk(CLS_LETTER, 3'd4, 6'b001000);
      "g": c = mk(CLS_LETTER, 3'd3, 6'b110000);
      "h": c = mk(CLS_LETTER, 3'd4, 6'b000000);
      "i": c = mk(CLS_LETTER, 3'd2, 6'b000000);
      "j": c = mk(CLS_LETTER, 3'd4, 6'b011100);
      "k": c = mk(CLS_LETTER, 3'd3, 6'b101000);
      "l": c = mk(CLS_LETTER, 3'd4, 6'b010000);
      "m": c = mk(CLS_LETTER, 3'd2, 6'b110000);
      "n": c = mk(CLS_LETTER, 3'd2, 6'b100000);
      "o": c = mk(CLS_LETTER, 3'd3, 6'b111000);
      "p": c = mk(CLS_LETTER, 3'd4, 6'b011000);
      "q": c = mk(CLS_LETTER, 3'd4, 6'b110100);
      "r": c = mk(CLS_LETTER, 3'd3, 6'b010000);
      "s": c = mk(CLS_LETTER, 3'd3, 6'b000000);
      "t": c = mk(CLS_LETTER, 3'd1, 6'b100000);
      "u": c = mk(CLS_LETTER, 3'd3, 6'b001000);
      "v": c = mk(CLS_LETTER, 3'd4, 6'b000100);
      "w": c = mk(CLS_LETTER, 3'd3, 6'b011000);
      "x": c = mk(CLS_LETTER, 3'd4, 6'b100100);
      "y": c = mk(CLS_LETTER, 3'd4, 6'b101100);
      "z": c = mk(CLS_LETTER, 3'd4, 6'b110000);
      "1": c = mk(CLS_DIGIT,  3'd5, 6'b011110);
      "2": c = mk(CLS_DIGIT,  3'd5, 6'b001110);
      "3": c = mk(CLS_DIGIT,  3'd5, 6'b000110);
      "4": c = mk(CLS_DIGIT,  3'd5, 6'b000010);
      "5": c = mk(CLS_DIGIT,  3'd5, 6'b000000);
      "6": c = mk(CLS_DIGIT,  3'd5, 6'b100000);
      "7": c = mk(CLS_DIGIT,  3'd5, 6'b110000);
      "8": c = mk(CLS_DIGIT,  3'd5, 6'b111000);
      "9": c = mk(CLS_DIGIT,  3'd5, 6'b111100);
      "0": c = mk(CLS_DIGIT,  3'd5, 6'b111110);
      ".": c = mk(CLS_SYMBOL, 3'd6, 6'b010101);
      ",": c = mk(CLS_SYMBOL, 3'd6, 6'b110011);
      "'": c = mk(CLS_SYMBOL, 3'd6, 6'b011110);
      8'h22: c = mk(CLS_SYMBOL, 3'd6, 6'b010010);
      "_": c = mk(CLS_SYMBOL, 3'd6, 6'b001101);
      ":": c = mk(CLS_SYMBOL, 3'd6, 6'b111000);
      ";": c = mk(CLS_SYMBOL, 3'd6, 6'b101010);
      "?": c = mk(CLS_SYMBOL, 3'd6, 6'b001100);
      "!": c = mk(CLS_SYMBOL, 3'd6, 6'b101011);
      "-": c = mk(CLS_SYMBOL, 3'd6, 6'b100001);
      "+": c = mk(CLS_SYMBOL, 3'd5, 6'b010100);
      "/": c = mk(CLS_SYMBOL, 3'd5, 6'b100100);
      "(": c = mk(CLS_SYMBOL, 3'd5, 6'b101100);
      ")": c = mk(CLS_SYMBOL, 3'd6, 6'b101101);
      "=": c = mk(CLS_SYMBOL, 3'd5, 6'b100010);
      "@": c = mk(CLS_SYMBOL, 3'd6, 6'b011010);
      default: c = '{found: 1'b0, cls: CLS_LETTER, len: 3'd0, bits: 6'd0};
    endcase
    return c;
  endfunction

endpackage

// File: design/mte_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text encoder: character decoder
// Looks up each accepted character, tracks the word state and registers the
// complete list of results for that character.
// ----------------------------------------------------------------------------
module mte_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable_digits,
  input  logic          enable_symbols,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    char_code,
  input  logic          text_end,
  output logic          job_valid,
  output mte_pkg::job_t job,
  input  logic          job_taken
);
  import mte_pkg::*;

  logic  job_valid_r, job_valid_nxt;
  job_t  job_r, job_nxt;
  logic  text_started_r, text_started_nxt;
  logic  inside_word_r, inside_word_nxt;
  logic  accept;
  logic  is_space;
  logic  coded;
  logic  gap;
  code_t code;
  job_t  new_job;
  logic  new_has_results;
  logic [2:0] pos;

  // The holding register frees up in the cycle the serialiser takes it.
  assign in_tready = !job_valid_r || job_taken;
  assign accept    = in_tvalid && in_tready;

  // Character classification and table lookup
  always_comb begin
    code     = morse_lookup(char_code);
    is_space = (char_code == 8'd32) || ((char_code >= 8'd9) && (char_code <= 8'd13));
    coded    = code.found && ((code.cls == CLS_LETTER) ||
                              ((code.cls == CLS_DIGIT) && enable_digits) ||
                              ((code.cls == CLS_SYMBOL) && enable_symbols));
    gap      = inside_word_r || text_started_r;
  end

  // Build the result list: an optional gap, then the dots and dashes, or a single error symbol for an uncoded character
  always_comb begin
    pos             = 3'd0;
    new_job.count   = 3'd1;
    new_job.syms    = '{default: SYM_DOT};
    new_has_results = !is_space;
    if (!coded) begin
      new_job.syms[0] = SYM_ERR;
    end else begin
      new_job.count = code.len + {2'b00, gap};
      for (int i = 0; i < MAX_SYMS; i++) begin
        pos = 3'(i) - {2'b00, gap};
        if (gap && (i == 0)) begin
          new_job.syms[i] = inside_word_r ? SYM_LGAP : SYM_WGAP;
        end else if (3'(i) < new_job.count) begin
          new_job.syms[i] = code.bits[3'd5 - pos] ? SYM_DASH : SYM_DOT;
        end
      end
    end
  end

  // Word state and holding register next values
  always_comb begin
    text_started_nxt = text_started_r;
    inside_word_nxt  = inside_word_r;
    job_valid_nxt    = job_valid_r && !job_taken;
    job_nxt          = job_r;
    if (accept) begin
      if (is_space) begin
        inside_word_nxt = 1'b0;
      end else if (coded) begin
        inside_word_nxt  = 1'b1;
        text_started_nxt = 1'b1;
      end
      if (text_end) begin
        inside_word_nxt  = 1'b0;
        text_started_nxt = 1'b0;
      end
      if (new_has_results) begin
        job_valid_nxt = 1'b1;
        job_nxt       = new_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r    <= 1'b0;
      text_started_r <= 1'b0;
      inside_word_r  <= 1'b0;
    end else begin
      job_valid_r    <= job_valid_nxt;
      text_started_r <= text_started_nxt;
      inside_word_r  <= inside_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

// File: design/mte_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text encoder: output serialiser
// Holds the results of one character and sends them one request per cycle
// while the receiver is ready, marking the final one.
// ----------------------------------------------------------------------------
module mte_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  mte_pkg::job_t job,
  output logic          job_taken,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    symbol,
  output logic          last
);
  import mte_pkg::*;

  logic emit_valid_r, emit_valid_nxt;
  job_t emit_r, emit_nxt;
  logic final_sym;
  logic done;

  assign final_sym = (emit_r.count == 3'd1);
  // Free when empty or when the final result leaves in this cycle
  assign done      = !emit_valid_r || (final_sym && out_tready);
  assign job_taken = done && job_valid;

  // Load a new list or shift the current one by one result
  always_comb begin
    emit_valid_nxt = emit_valid_r;
    emit_nxt       = emit_r;
    if (done) begin
      emit_valid_nxt = job_valid;
      emit_nxt       = job;
    end else if (out_tready) begin
      emit_nxt.count = emit_r.count - 3'd1;
      for (int i = 0; i < MAX_SYMS - 1; i++) begin
        emit_nxt.syms[i] = emit_r.syms[i+1];
      end
      emit_nxt.syms[MAX_SYMS-1] = SYM_DOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_valid_r <= 1'b0;
    end else begin
      emit_valid_r <= emit_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_r <= emit_nxt;
  end

  assign out_tvalid = emit_valid_r;
  assign symbol     = emit_r.syms[0];
  assign last       = final_sym;

endmodule

// File: design/morse_text_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text encoder, top level
// Converts a stream of ASCII characters into International Morse symbols.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one character per request in in_tdata, with
//   in_tlast marking the last character of a text. The output stream carries
//   one symbol per request (dot, dash, letter gap, word gap or unknown
//   character), and out_tlast marks the final symbol caused by a character.
//   Whitespace is absorbed and causes no output request.
//   Each character passes the holding and serialiser registers. Throughput:
//   one output symbol per cycle when not stalled; a character holds the
//   serialiser until its 1 to 7 symbols have left, so a character is accepted
//   every cycle only while each causes a single symbol. Configuration writes
//   through cfg_we/cfg_index/cfg_wdata enable digits and punctuation; the
//   user, not the block, must make them only while the block is idle. Reset
//   clears both enables, the word state and all pending symbols. When the
//   receiver stalls, the serialiser holds its symbol and one more decoded
//   character waits in the holding register before in_tready drops.
// ----------------------------------------------------------------------------
module morse_text_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // text_end
  // Output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] symbol, [7:3] zero
  output logic       out_tlast   // last
);
  import mte_pkg::*;

  logic       enable_digits_r;
  logic       enable_symbols_r;
  logic       job_valid;
  job_t       job;
  logic       job_taken;
  logic [2:0] symbol;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_digits_r  <= 1'b0;
      enable_symbols_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE_DIGITS:  enable_digits_r  <= cfg_wdata;
        REG_ENABLE_SYMBOLS: enable_symbols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mte_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .enable_digits  (enable_digits_r),
    .enable_symbols (enable_symbols_r),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .char_code      (in_tdata),
    .text_end       (in_tlast),
    .job_valid      (job_valid),
    .job            (job),
    .job_taken      (job_taken)
  );

  mte_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_taken  (job_taken),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .symbol     (symbol),
    .last       (out_tlast)
  );

  assign out_tdata = {5'd0, symbol};

endmodule
